>>> hw/rtl/qac_pkg.sv
// Shared widths, constants and interface types for the quad area and centroid core.
// Used by qac_geom, qac_div and quad_area_centroid_core; depends on nothing.
package qac_pkg;

    // Coordinate and derived operand widths.
    localparam int CW     = 16;          // coordinate, signed
    localparam int DW     = CW + 1;      // edge delta or coordinate sum
    localparam int PW     = 2 * CW;      // y*z product
    localparam int XW     = PW + 1;      // sum of two cross products
    localparam int TW     = 2 * DW;      // area term dz*(yj+yi)
    localparam int WW     = PW + 3;      // edge weight 2yizi+2yjzj+yizj+yjzi
    localparam int AW     = 36;          // twice the area
    localparam int MW     = DW + WW;     // moment term d*w
    localparam int NW     = MW + 4;      // moment sum
    localparam int DENW   = AW + 2;      // 3 * area sum, signed
    localparam int ADW    = DENW - 1;    // magnitude of the denominator
    localparam int RW     = NW + 1;      // partial remainder of the divider
    localparam int QB     = CW + 1;      // quotient bits of 2|n|/|d|
    localparam int NV     = 4;           // vertices

    // Pipeline depths.
    localparam int GEOM_LAT = 4;
    localparam int DIV_LAT  = QB + 3;
    localparam int PIPE_LAT = GEOM_LAT + DIV_LAT;

    // Packed port widths.
    localparam int IN_BITS  = 2 * NV * CW;
    localparam int OUT_BITS = AW + 2 * CW + 2;
    localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8;

    typedef logic signed [CW-1:0] coord_t;

    // Results of the geometry stages handed to the dividers.
    typedef struct packed {
        logic signed [NW-1:0]   num_y;
        logic signed [NW-1:0]   num_z;
        logic signed [DENW-1:0] den;
        logic signed [AW-1:0]   area;
        logic                   degenerate;
    } geom_out_t;

    // One rounded and saturated centroid coordinate.
    typedef struct packed {
        logic signed [CW-1:0] value;
        logic                 sat;
    } div_out_t;

    // Fields that travel beside the dividers.
    typedef struct packed {
        logic signed [AW-1:0] area;
        logic                 degenerate;
    } side_t;

endpackage

>>> hw/rtl/quad_area_centroid_core.sv
// Top level of the quad area and centroid core: stream ports, valid pipeline, output word.
// Depends on qac_pkg, qac_geom and qac_div.
//
//  Channel | Direction | Word
//  s_      | in        | eight Q8.8 coordinates of one quadrilateral
//  m_      | out       | twice the signed area, centroid y and z, degenerate, saturated
//
// One word is accepted per cycle while the pipeline is not held; each result passes
// through 4 geometry stages and a divider of 17 quotient-bit stages plus 3 more.
// The whole pipeline holds while m_tvalid is high and m_tready is low, and s_tready
// drops with it; bubbles inside the pipeline are not squeezed out during the hold.
// Reset clears only the valid bits.
module quad_area_centroid_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    // vertex0_y, vertex0_z, vertex1_y, vertex1_z, vertex2_y, vertex2_z,
    // vertex3_y, vertex3_z, 16 bits each, from bit 0 up
    input  logic [qac_pkg::IN_BITS-1:0]  s_tdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // twice the signed area [35:0], centroid_y[51:36], centroid_z[67:52], degenerate[68],
    // saturated[69], zero fill [71:70]
    output logic [qac_pkg::OUT_TW-1:0]   m_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready
);

    logic ce;
    logic v_reg [qac_pkg::PIPE_LAT];
    qac_pkg::side_t side_reg [qac_pkg::DIV_LAT];

    qac_pkg::coord_t [qac_pkg::NV-1:0] vy;
    qac_pkg::coord_t [qac_pkg::NV-1:0] vz;
    qac_pkg::geom_out_t geom;
    qac_pkg::div_out_t  res_y;
    qac_pkg::div_out_t  res_z;

    // Advance the pipeline unless a finished word is held at the output.
    assign ce       = !v_reg[qac_pkg::PIPE_LAT-1] || m_tready;
    assign s_tready = ce;
    assign m_tvalid = v_reg[qac_pkg::PIPE_LAT-1];

    // Unpack the vertices.
    always_comb begin
        for (int i = 0; i < qac_pkg::NV; i++) begin
            vy[i] = s_tdata[(2 * i) * qac_pkg::CW +: qac_pkg::CW];
            vz[i] = s_tdata[(2 * i + 1) * qac_pkg::CW +: qac_pkg::CW];
        end
    end

    qac_geom u_geom (
        .aclk (aclk),
        .ce   (ce),
        .vy   (vy),
        .vz   (vz),
        .geom (geom)
    );

    qac_div u_div_y (
        .aclk   (aclk),
        .ce     (ce),
        .num    (geom.num_y),
        .den    (geom.den),
        .result (res_y)
    );

    qac_div u_div_z (
        .aclk   (aclk),
        .ce     (ce),
        .num    (geom.num_z),
        .den    (geom.den),
        .result (res_z)
    );

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < qac_pkg::PIPE_LAT; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (ce) begin
            v_reg[0] <= s_tvalid;
            for (int k = 1; k < qac_pkg::PIPE_LAT; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // Area and degenerate flag wait beside the dividers.
    always_ff @(posedge aclk) begin
        if (ce) begin
            side_reg[0].area       <= geom.area;
            side_reg[0].degenerate <= geom.degenerate;
            for (int k = 1; k < qac_pkg::DIV_LAT; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Output word; a zero area forces the centroid and the clip flag to zero.
    always_comb begin
        qac_pkg::side_t sd;
        sd      = side_reg[qac_pkg::DIV_LAT-1];
        m_tdata = '0;
        m_tdata[qac_pkg::AW-1:0] = sd.area;
        m_tdata[qac_pkg::AW +: qac_pkg::CW] = sd.degenerate ? '0 : res_y.value;
        m_tdata[qac_pkg::AW + qac_pkg::CW +: qac_pkg::CW] = sd.degenerate ? '0 : res_z.value;
        m_tdata[qac_pkg::AW + 2 * qac_pkg::CW]     = sd.degenerate;
        m_tdata[qac_pkg::AW + 2 * qac_pkg::CW + 1] = !sd.degenerate && (res_y.sat || res_z.sat);
    end

endmodule

>>> hw/rtl/qac_geom.sv
// Geometry stages: edge products, shoelace area and first moments of a quad.
// Depends on qac_pkg.
module qac_geom (
    input  logic                           aclk,
    input  logic                           ce,
    input  qac_pkg::coord_t [qac_pkg::NV-1:0] vy,
    input  qac_pkg::coord_t [qac_pkg::NV-1:0] vz,
    output qac_pkg::geom_out_t             geom
);

    // Stage 1 registers.
    logic signed [qac_pkg::DW-1:0] dy1_reg [qac_pkg::NV];
    logic signed [qac_pkg::DW-1:0] dz1_reg [qac_pkg::NV];
    logic signed [qac_pkg::PW-1:0] p1_reg  [qac_pkg::NV];
    logic signed [qac_pkg::XW-1:0] c1_reg  [qac_pkg::NV];
    logic signed [qac_pkg::TW-1:0] t1_reg  [qac_pkg::NV];
    // Stage 2 registers.
    logic signed [qac_pkg::DW-1:0] dy2_reg [qac_pkg::NV];
    logic signed [qac_pkg::DW-1:0] dz2_reg [qac_pkg::NV];
    logic signed [qac_pkg::WW-1:0] w2_reg  [qac_pkg::NV];
    logic signed [qac_pkg::AW-1:0] s2_reg;
    // Stage 3 registers.
    logic signed [qac_pkg::MW-1:0] my3_reg [qac_pkg::NV];
    logic signed [qac_pkg::MW-1:0] mz3_reg [qac_pkg::NV];
    logic signed [qac_pkg::AW-1:0] s3_reg;
    // Stage 4 register.
    qac_pkg::geom_out_t geom_reg;

    // Stage 1 combinational terms.
    logic signed [qac_pkg::DW-1:0] dy1_next [qac_pkg::NV];
    logic signed [qac_pkg::DW-1:0] dz1_next [qac_pkg::NV];
    logic signed [qac_pkg::PW-1:0] p1_next  [qac_pkg::NV];
    logic signed [qac_pkg::XW-1:0] c1_next  [qac_pkg::NV];
    logic signed [qac_pkg::TW-1:0] t1_next  [qac_pkg::NV];

    // Edge deltas, vertex products, cross products and area terms.
    always_comb begin
        logic signed [qac_pkg::DW-1:0] ysum;
        logic signed [qac_pkg::PW-1:0] ca;
        logic signed [qac_pkg::PW-1:0] cb;
        ysum = '0;
        ca   = '0;
        cb   = '0;
        for (int i = 0; i < qac_pkg::NV; i++) begin
            dy1_next[i] = qac_pkg::DW'(vy[(i + 1) % qac_pkg::NV]) - qac_pkg::DW'(vy[i]);
            dz1_next[i] = qac_pkg::DW'(vz[(i + 1) % qac_pkg::NV]) - qac_pkg::DW'(vz[i]);
            ysum        = qac_pkg::DW'(vy[(i + 1) % qac_pkg::NV]) + qac_pkg::DW'(vy[i]);
            p1_next[i]  = vy[i] * vz[i];
            ca          = vy[i] * vz[(i + 1) % qac_pkg::NV];
            cb          = vy[(i + 1) % qac_pkg::NV] * vz[i];
            c1_next[i]  = qac_pkg::XW'(ca) + qac_pkg::XW'(cb);
            t1_next[i]  = dz1_next[i] * ysum;
        end
    end

    // Stage 2 combinational terms: edge weights and the area sum.
    logic signed [qac_pkg::WW-1:0] w2_next [qac_pkg::NV];
    logic signed [qac_pkg::AW-1:0] s2_next;

    always_comb begin
        logic signed [qac_pkg::WW-1:0] pp;
        pp      = '0;
        s2_next = '0;
        for (int i = 0; i < qac_pkg::NV; i++) begin
            pp = qac_pkg::WW'(p1_reg[i]) + qac_pkg::WW'(p1_reg[(i + 1) % qac_pkg::NV]);
            w2_next[i] = (pp <<< 1) + qac_pkg::WW'(c1_reg[i]);
            s2_next    = s2_next + qac_pkg::AW'(t1_reg[i]);
        end
    end

    // Stage 3 combinational terms: moment products.
    logic signed [qac_pkg::MW-1:0] my3_next [qac_pkg::NV];
    logic signed [qac_pkg::MW-1:0] mz3_next [qac_pkg::NV];

    always_comb begin
        for (int i = 0; i < qac_pkg::NV; i++) begin
            my3_next[i] = dy2_reg[i] * w2_reg[i];
            mz3_next[i] = dz2_reg[i] * w2_reg[i];
        end
    end

    // Stage 4 combinational terms: moment sums and the denominator.
    qac_pkg::geom_out_t geom_next;

    always_comb begin
        logic signed [qac_pkg::NW-1:0]   sy;
        logic signed [qac_pkg::NW-1:0]   sz;
        logic signed [qac_pkg::DENW-1:0] s3x;
        sy = '0;
        sz = '0;
        for (int i = 0; i < qac_pkg::NV; i++) begin
            sy = sy + qac_pkg::NW'(my3_reg[i]);
            sz = sz + qac_pkg::NW'(mz3_reg[i]);
        end
        s3x                  = qac_pkg::DENW'(s3_reg);
        geom_next.num_y      = -sy;
        geom_next.num_z      = sz;
        geom_next.den        = s3x + (s3x <<< 1);
        geom_next.area       = s3_reg;
        geom_next.degenerate = (s3_reg == '0);
    end

    // Pipeline registers, all held together on a stall.
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < qac_pkg::NV; i++) begin
                dy1_reg[i] <= dy1_next[i];
                dz1_reg[i] <= dz1_next[i];
                p1_reg[i]  <= p1_next[i];
                c1_reg[i]  <= c1_next[i];
                t1_reg[i]  <= t1_next[i];
                dy2_reg[i] <= dy1_reg[i];
                dz2_reg[i] <= dz1_reg[i];
                w2_reg[i]  <= w2_next[i];
                my3_reg[i] <= my3_next[i];
                mz3_reg[i] <= mz3_next[i];
            end
            s2_reg   <= s2_next;
            s3_reg   <= s2_reg;
            geom_reg <= geom_next;
        end
    end

    assign geom = geom_reg;

endmodule

>>> hw/rtl/qac_div.sv
// Pipelined restoring divider: signed moment over signed denominator, rounded to
// nearest with ties away from zero and saturated to the coordinate range. Uses qac_pkg.
module qac_div (
    input  logic                            aclk,
    input  logic                            ce,
    input  logic signed [qac_pkg::NW-1:0]   num,
    input  logic signed [qac_pkg::DENW-1:0] den,
    output qac_pkg::div_out_t               result
);

    localparam logic [qac_pkg::QB-1:0] LIM_POS = qac_pkg::QB'(2 ** (qac_pkg::CW - 1) - 1);
    localparam logic [qac_pkg::QB-1:0] LIM_NEG = qac_pkg::QB'(2 ** (qac_pkg::CW - 1));

    // Stage A: magnitudes and result sign.
    logic [qac_pkg::RW-1:0]  na_reg;
    logic [qac_pkg::ADW-1:0] da_reg;
    logic                    nega_reg;

    // Stage B and the quotient bit stages.
    logic [qac_pkg::RW-1:0]  r_reg   [qac_pkg::QB+1];
    logic [qac_pkg::QB-1:0]  q_reg   [qac_pkg::QB+1];
    logic [qac_pkg::ADW-1:0] d_reg   [qac_pkg::QB+1];
    logic                    neg_reg [qac_pkg::QB+1];
    logic                    ovf_reg [qac_pkg::QB+1];

    qac_pkg::div_out_t result_reg;

    // Magnitudes; the numerator is doubled so that the last quotient bit rounds.
    logic [qac_pkg::NW-1:0]   an;
    logic [qac_pkg::DENW-1:0] ad;
    always_comb begin
        an = num[qac_pkg::NW-1] ? qac_pkg::NW'(-num) : qac_pkg::NW'(num);
        ad = den[qac_pkg::DENW-1] ? qac_pkg::DENW'(-den) : qac_pkg::DENW'(den);
    end

    // Quotients of 2^QB or more saturate in any case.
    logic ovf_next;
    assign ovf_next = na_reg >= (qac_pkg::RW'(da_reg) << qac_pkg::QB);

    // One quotient bit per stage, most significant first.
    logic [qac_pkg::RW-1:0] r_next [qac_pkg::QB];
    logic [qac_pkg::QB-1:0] q_next [qac_pkg::QB];
    always_comb begin
        logic [qac_pkg::RW-1:0] sh;
        sh = '0;
        for (int s = 0; s < qac_pkg::QB; s++) begin
            sh = qac_pkg::RW'(d_reg[s]) << (qac_pkg::QB - 1 - s);
            if (r_reg[s] >= sh) begin
                r_next[s] = r_reg[s] - sh;
                q_next[s] = {q_reg[s][qac_pkg::QB-2:0], 1'b1};
            end else begin
                r_next[s] = r_reg[s];
                q_next[s] = {q_reg[s][qac_pkg::QB-2:0], 1'b0};
            end
        end
    end

    // Rounding, saturation and sign.
    qac_pkg::div_out_t result_next;
    always_comb begin
        logic [qac_pkg::QB:0]   qinc;
        logic [qac_pkg::QB-1:0] qr;
        logic                   neg;
        logic                   sat;
        qinc = qac_pkg::QB'(q_reg[qac_pkg::QB]) + (qac_pkg::QB + 1)'(1);
        qr   = qinc[qac_pkg::QB:1];
        neg  = neg_reg[qac_pkg::QB];
        sat  = ovf_reg[qac_pkg::QB] || (!neg && (qr > LIM_POS)) || (neg && (qr > LIM_NEG));
        result_next.sat = sat;
        if (sat) begin
            result_next.value = neg ? qac_pkg::CW'(LIM_NEG) : qac_pkg::CW'(LIM_POS);
        end else begin
            result_next.value = neg ? -qac_pkg::CW'(qr) : qac_pkg::CW'(qr);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            na_reg     <= {an, 1'b0};
            da_reg     <= qac_pkg::ADW'(ad);
            nega_reg   <= num[qac_pkg::NW-1] ^ den[qac_pkg::DENW-1];
            r_reg[0]   <= na_reg;
            q_reg[0]   <= '0;
            d_reg[0]   <= da_reg;
            neg_reg[0] <= nega_reg;
            ovf_reg[0] <= ovf_next;
            for (int s = 0; s < qac_pkg::QB; s++) begin
                r_reg[s+1]   <= r_next[s];
                q_reg[s+1]   <= q_next[s];
                d_reg[s+1]   <= d_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                ovf_reg[s+1] <= ovf_reg[s];
            end
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
